/* hdl/bsc_pkg.sv */
// Package for the barometric sensor compensation block.
// Constants and the truncating constant divide helper; no dependencies.
package bsc_pkg;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B1_B2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MC_MD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OSS     = 3'd5;

    localparam logic signed [31:0] B6_OFFSET = 32'sd4000;
    localparam logic signed [31:0] T_ROUND   = 32'sd8;
    localparam logic signed [31:0] B4_OFFSET = 32'sd32768;
    localparam logic [31:0]        B7_SCALE  = 32'd50000;
    localparam logic signed [31:0] P_COEF1   = 32'sd3038;
    localparam logic signed [31:0] P_COEF2   = -32'sd7357;
    localparam logic signed [31:0] P_OFFSET  = 32'sd3791;
    localparam logic [31:0]        HALF_RANGE = 32'h8000_0000;

    // signed divide by 2**k, rounding toward zero
    function automatic logic signed [31:0] divc(input logic signed [31:0] a, input int k);
        logic signed [31:0] bias;
        bias = a[31] ? $signed((32'd1 << k) - 32'd1) : 32'sd0;
        return (a + bias) >>> k;
    endfunction
endpackage

/* hdl/bsc_if.sv */
// Handshake interfaces for input items, result items and configuration writes.
// Depends on bsc_pkg.
interface bsc_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [23:0] raw_reading;
    modport source (output valid, operation, raw_reading, input ready);
    modport sink   (input valid, operation, raw_reading, output ready);
endinterface

interface bsc_out_if;
    logic               valid;
    logic               ready;
    logic               is_pressure;
    logic signed [15:0] temperature_tenths;
    logic signed [31:0] pressure_pascals;
    logic               divide_fault;
    modport source (output valid, is_pressure, temperature_tenths, pressure_pascals,
                    divide_fault, input ready);
    modport sink   (input valid, is_pressure, temperature_tenths, pressure_pascals,
                    divide_fault, output ready);
endinterface

interface bsc_cfg_if import bsc_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/barometric_sensor_compensation.sv */
// Top level: integer temperature and pressure compensation for a barometer.
// Depends on bsc_pkg and the interfaces in bsc_if.sv.
//
//  channel  dir  content
//  i_in     in   operation, raw_reading
//  o_out    out  is_pressure, temperature_tenths, pressure_pascals, divide_fault
//  i_cfg    in   index, data (calibration words, oversampling)
//
// A temperature item and a pressure item both use the 32-step restoring divider
// and the single shared 32x32 multiplier; a zero divisor skips the 32 divider
// steps. The block returns to idle before it takes the next item.
// Input ready only while idle; a result waiting in the output register does
// not block a new item, but the next result waits until it is taken.
// Synchronous active-low reset clears control, calibration words, oversampling, stored b5 and last values.
module barometric_sensor_compensation import bsc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsc_in_if.sink    i_in,
    bsc_out_if.source o_out,
    bsc_cfg_if.sink   i_cfg
);
    typedef enum logic [4:0] {
        S_IDLE, S_T0, S_T1, S_T2, S_DIV, S_T3,
        S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_P10,
        S_P11, S_P12, S_P13, S_P14, S_P15, S_P16, S_P17, S_P18, S_P19, S_P20,
        S_DONE
    } t_state;

    t_state r_state;
    logic [31:0] r_cal0, r_cal1, r_cal2, r_cal3, r_cal4;
    logic [1:0]  r_oss;
    logic        r_op;
    logic [23:0] r_raw;
    logic [23:0] r_up;
    logic signed [31:0] r_a, r_x1, r_sq, r_b6, r_b3, r_t, r_p, r_b5, r_last_p;
    logic [31:0] r_b4;
    logic signed [15:0] r_last_t;
    logic        r_fault;
    logic [32:0] r_rem;
    logic [31:0] r_quo, r_den;
    logic [4:0]  r_cnt;
    logic        r_neg, r_dbl;
    logic        r_out_valid;

    logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic signed [31:0] mul_a, mul_b, mul_p;
    logic signed [31:0] den_t, num_t, quo_s, b5, tq, x2, x3, sum_s, p8;
    logic [32:0] shifted;

    assign ac1 = 32'(signed'(r_cal0[31:16]));
    assign ac2 = 32'(signed'(r_cal0[15:0]));
    assign ac3 = 32'(signed'(r_cal1[31:16]));
    assign ac4 = $signed({16'd0, r_cal1[15:0]});
    assign ac5 = $signed({16'd0, r_cal2[31:16]});
    assign ac6 = $signed({16'd0, r_cal2[15:0]});
    assign b1  = 32'(signed'(r_cal3[31:16]));
    assign b2  = 32'(signed'(r_cal3[15:0]));
    assign mc  = 32'(signed'(r_cal4[31:16]));
    assign md  = 32'(signed'(r_cal4[15:0]));

    assign p8 = divc(r_p, 8);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_T0:  begin mul_a = $signed({16'd0, r_raw[15:0]}) - ac6; mul_b = ac5; end
            S_P1:  begin mul_a = r_b6; mul_b = r_b6; end
            S_P3:  begin mul_a = b2;   mul_b = r_sq; end
            S_P5:  begin mul_a = ac2;  mul_b = r_b6; end
            S_P7:  begin mul_a = ac3;  mul_b = r_b6; end
            S_P9:  begin mul_a = b1;   mul_b = r_sq; end
            S_P11: begin mul_a = ac4;  mul_b = r_t; end
            S_P13: begin
                mul_a = $signed({8'd0, r_up}) - r_b3;
                mul_b = $signed(B7_SCALE >> r_oss);
            end
            S_P16: begin mul_a = p8;  mul_b = p8; end
            S_P17: begin mul_a = r_a; mul_b = P_COEF1; end
            S_P19: begin mul_a = P_COEF2; mul_b = r_p; end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign num_t   = mc <<< 11;
    assign den_t   = r_x1 + md;
    assign quo_s   = r_neg ? -$signed(r_quo) : $signed(r_quo);
    assign b5      = r_x1 + quo_s;
    assign tq      = divc(b5 + T_ROUND, 4);
    assign x2      = divc(r_a, 11);
    assign sum_s   = (ac1 <<< 2) + r_x1 + x2;
    assign x3      = divc(r_x1 + divc(r_a, 16) + 32'sd2, 2);
    assign shifted = {r_rem[31:0], r_quo[31]};

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cal0      <= '0;
            r_cal1      <= '0;
            r_cal2      <= '0;
            r_cal3      <= '0;
            r_cal4      <= '0;
            r_oss       <= '0;
            r_b5        <= '0;
            r_last_t    <= '0;
            r_last_p    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_AC1_AC2: r_cal0 <= i_cfg.data;
                    REG_AC3_AC4: r_cal1 <= i_cfg.data;
                    REG_AC5_AC6: r_cal2 <= i_cfg.data;
                    REG_B1_B2:   r_cal3 <= i_cfg.data;
                    REG_MC_MD:   r_cal4 <= i_cfg.data;
                    REG_OSS:     r_oss  <= i_cfg.data[1:0];
                    default: ;
                endcase
            end
            if (r_out_valid && o_out.ready && r_state != S_DONE) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: if (i_in.valid) begin
                    r_op    <= i_in.operation;
                    r_raw   <= i_in.raw_reading;
                    r_fault <= 1'b0;
                    r_state <= i_in.operation ? S_P0 : S_T0;
                end
                S_T0: begin r_a <= mul_p; r_state <= S_T1; end
                S_T1: begin r_x1 <= divc(r_a, 15); r_state <= S_T2; end
                S_T2: begin
                    r_rem <= '0;
                    r_cnt <= '0;
                    r_den <= den_t[31] ? 32'(-den_t) : 32'(den_t);
                    if (den_t == 0) begin
                        r_fault <= 1'b1;
                        r_quo   <= '0;
                        r_neg   <= 1'b0;
                        r_state <= S_T3;
                    end else begin
                        r_neg   <= num_t[31] ^ den_t[31];
                        r_quo   <= num_t[31] ? 32'(-num_t) : 32'(num_t);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (shifted >= {1'b0, r_den}) begin
                        r_rem <= shifted - {1'b0, r_den};
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= shifted;
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) r_state <= r_op ? S_P15 : S_T3;
                end
                S_T3: begin
                    r_b5 <= b5;
                    if (tq > 32'sd32767)       r_last_t <= 16'sh7FFF;
                    else if (tq < -32'sd32768) r_last_t <= 16'sh8000;
                    else                       r_last_t <= tq[15:0];
                    r_state <= S_DONE;
                end
                S_P0: begin
                    r_b6    <= r_b5 - B6_OFFSET;
                    r_up    <= r_raw >> (4'd8 - {2'd0, r_oss});
                    r_state <= S_P1;
                end
                S_P1:  begin r_a <= mul_p; r_state <= S_P2; end
                S_P2:  begin r_sq <= divc(r_a, 12); r_state <= S_P3; end
                S_P3:  begin r_a <= mul_p; r_state <= S_P4; end
                S_P4:  begin r_x1 <= divc(r_a, 11); r_state <= S_P5; end
                S_P5:  begin r_a <= mul_p; r_state <= S_P6; end
                S_P6:  begin r_b3 <= divc((sum_s <<< r_oss) + 32'sd2, 2); r_state <= S_P7; end
                S_P7:  begin r_a <= mul_p; r_state <= S_P8; end
                S_P8:  begin r_x1 <= divc(r_a, 13); r_state <= S_P9; end
                S_P9:  begin r_a <= mul_p; r_state <= S_P10; end
                S_P10: begin r_t <= x3 + B4_OFFSET; r_state <= S_P11; end
                S_P11: begin r_a <= mul_p; r_state <= S_P12; end
                S_P12: begin r_b4 <= 32'(r_a[31:15]); r_state <= S_P13; end
                S_P13: begin r_a <= mul_p; r_state <= S_P14; end
                S_P14: begin
                    r_rem <= '0;
                    r_cnt <= '0;
                    r_neg <= 1'b0;
                    r_den <= r_b4;
                    if (r_b4 == 0) begin
                        r_fault <= 1'b1;
                        r_quo   <= '0;
                        r_dbl   <= 1'b0;
                        r_state <= S_P15;
                    end else if (r_a < HALF_RANGE) begin
                        r_quo   <= r_a << 1;
                        r_dbl   <= 1'b0;
                        r_state <= S_DIV;
                    end else begin
                        r_quo   <= r_a;
                        r_dbl   <= 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_P15: begin
                    r_p     <= r_dbl ? $signed(r_quo << 1) : $signed(r_quo);
                    r_state <= S_P16;
                end
                S_P16: begin r_a <= mul_p; r_state <= S_P17; end
                S_P17: begin r_a <= mul_p; r_state <= S_P18; end
                S_P18: begin r_x1 <= divc(r_a, 16); r_state <= S_P19; end
                S_P19: begin r_a <= mul_p; r_state <= S_P20; end
                S_P20: begin
                    r_last_p <= r_p + divc(r_x1 + divc(r_a, 16) + P_OFFSET, 4);
                    r_state  <= S_DONE;
                end
                S_DONE: if (!r_out_valid || o_out.ready) begin
                    r_out_valid              <= 1'b1;
                    o_out.is_pressure        <= r_op;
                    o_out.temperature_tenths <= r_last_t;
                    o_out.pressure_pascals   <= r_last_p;
                    o_out.divide_fault       <= r_fault;
                    r_state                  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* hdl/bsc_checker.sv */
// Port-level checks for barometric_sensor_compensation, and the bind that attaches them.
// Depends on the top level's interface ports only.
module bsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_pressure
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("new item taken while computing");
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result without preceding work");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_pressure))
        else $error("stalled result changed");
endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_pressure (o_out.pressure_pascals)
);
